// File: rtl/kruskal_spanning_tree_savings_assert.svh
// Assertion macros for the spanning-tree savings block.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef KRUSKAL_SPANNING_TREE_SAVINGS_ASSERT_SVH
`define KRUSKAL_SPANNING_TREE_SAVINGS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define KST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define KST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/kst_pkg.sv
// Shared constants and types for the spanning-tree savings block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kst_pkg;

  localparam int unsigned NODE_W      = 10;
  localparam int unsigned WIN_W       = 16;
  localparam int unsigned SUM_W       = 26;
  localparam int unsigned TCNT_W      = 10;
  localparam int unsigned NCFG_W      = 11;
  localparam int unsigned NCFG_RESET  = 1024;

  localparam int unsigned MAX_NODES_DEF   = 1024;
  localparam int unsigned MAX_EDGES_DEF   = 1024;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  typedef enum logic [10:0] {
    S_LOAD = 11'b000_0000_0001,
    S_CLR  = 11'b000_0000_0010,
    S_KRD  = 11'b000_0000_0100,
    S_KLD  = 11'b000_0000_1000,
    S_CMP  = 11'b000_0001_0000,
    S_PUT  = 11'b000_0010_0000,
    S_ERD  = 11'b000_0100_0000,
    S_ELD  = 11'b000_1000_0000,
    S_WA   = 11'b001_0000_0000,
    S_WB   = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_e;

endpackage
`default_nettype wire

// File: rtl/kst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module kst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/kruskal_spanning_tree_savings.sv
// Spanning-forest savings: edge load, in-place insertion sort, union-find.
// Depends on kst_pkg, kst_ram and kruskal_spanning_tree_savings_assert.svh.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one edge per request:
//    src_node_i, dst_node_i, weight_i, last_i. While loading, one edge is
//    taken per cycle. Edges beyond MAX_EDGES are dropped but last still ends
//    the graph.
//  - After the last edge the block is busy (in_ready_o low): it rebuilds all
//    MAX_NODES entries of the parent table, then runs an insertion sort over
//    the edge RAM (one shift per cycle), then reads each edge and, for an
//    in-range edge while the forest is not full, walks both endpoints to
//    their roots. Each RAM has one write port and one read port.
//  - Output channel (out_valid_o/out_ready_i) gives one result per graph:
//    savings_o, tree_edges_o, bad_edge_o, held in an output register. Loading
//    of the next graph proceeds while it waits; a stalled receiver only
//    holds the block at the end of the next graph.
//  - cfg_we_i writes node_count; it is sampled when the last edge arrives.
//  - Reset (rst_ni low, async) empties the graph, drops any pending result
//    and sets node_count to 1024.
`timescale 1ns / 1ps
`default_nettype none
module kruskal_spanning_tree_savings #(
  parameter int unsigned MAX_NODES   = kst_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES   = kst_pkg::MAX_EDGES_DEF,
  parameter int unsigned WEIGHT_BITS = kst_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [kst_pkg::NCFG_W-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [kst_pkg::NODE_W-1:0]  src_node_i,
  input  wire logic [kst_pkg::NODE_W-1:0]  dst_node_i,
  input  wire logic [kst_pkg::WIN_W-1:0]   weight_i,
  input  wire logic                        last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [kst_pkg::SUM_W-1:0]        savings_o,
  output logic [kst_pkg::TCNT_W-1:0]       tree_edges_o,
  output logic                             bad_edge_o
);

  localparam int unsigned NW   = kst_pkg::NODE_W;
  localparam int unsigned SW   = kst_pkg::SUM_W;
  localparam int unsigned EW   = 2 * NW + WEIGHT_BITS;
  localparam int unsigned EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned NAW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned NCW  = $clog2(MAX_NODES + 1);

  kst_pkg::state_e state_q, state_d;

  logic [kst_pkg::NCFG_W-1:0] ncfg_q;
  logic [NCW-1:0]   nodes_q, nodes_d;
  logic [ECW-1:0]   ecnt_q, ecnt_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [SW-1:0]    tot_q, tot_d, tsum_q, tsum_d;
  logic [NCW-1:0]   tc_q, tc_d;
  logic             bad_q, bad_d;
  logic [EW-1:0]    key_q, key_d;
  logic [NAW-1:0]   x_q, x_d, ra_q, ra_d, b_q, b_d;
  logic [WEIGHT_BITS-1:0] ew_q, ew_d;
  logic             ov_q, ov_d;
  logic [SW-1:0]    sav_q, sav_d;
  logic [kst_pkg::TCNT_W-1:0] te_q, te_d;
  logic             be_q, be_d;

  logic             e_we;
  logic [EAW-1:0]   e_waddr, e_raddr;
  logic [EW-1:0]    e_wdata, e_rdata;
  logic             p_we;
  logic [NAW-1:0]   p_waddr, p_wdata, p_raddr, p_rdata;

  logic [WEIGHT_BITS-1:0] w_in;
  logic [NW-1:0]    r_src, r_dst;
  logic [WEIGHT_BITS-1:0] r_w, key_w;
  logic             in_acc;

  kst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  kst_ram #(.WIDTH(NAW), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  assign w_in   = WEIGHT_BITS'(weight_i);
  assign r_src  = e_rdata[EW-1 -: NW];
  assign r_dst  = e_rdata[EW-NW-1 -: NW];
  assign r_w    = e_rdata[WEIGHT_BITS-1:0];
  assign key_w  = key_q[WEIGHT_BITS-1:0];
  assign in_ready_o = (state_q == kst_pkg::S_LOAD);
  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    nodes_d = nodes_q;
    ecnt_d  = ecnt_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    tot_d   = tot_q;
    tsum_d  = tsum_q;
    tc_d    = tc_q;
    bad_d   = bad_q;
    key_d   = key_q;
    x_d     = x_q;
    ra_d    = ra_q;
    b_d     = b_q;
    ew_d    = ew_q;
    ov_d    = ov_q && !out_ready_i;
    sav_d   = sav_q;
    te_d    = te_q;
    be_d    = be_q;
    e_we    = 1'b0;
    e_waddr = EAW'(ecnt_q);
    e_wdata = {src_node_i, dst_node_i, w_in};
    e_raddr = EAW'(i_q);
    p_we    = 1'b0;
    p_waddr = x_q;
    p_wdata = x_q;
    p_raddr = x_q;

    case (state_q)
      kst_pkg::S_LOAD: begin
        if (in_acc) begin
          if (32'(ecnt_q) < MAX_EDGES) begin
            e_we   = 1'b1;
            ecnt_d = ecnt_q + 1'b1;
            tot_d  = tot_q + SW'(w_in);
          end
          if (last_i) begin
            nodes_d = (32'(ncfg_q) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(ncfg_q);
            x_d     = '0;
            tsum_d  = '0;
            tc_d    = '0;
            state_d = kst_pkg::S_CLR;
          end
        end
      end
      kst_pkg::S_CLR: begin
        p_we = 1'b1;
        x_d  = x_q + 1'b1;
        if (32'(x_q) == MAX_NODES - 1) begin
          i_d     = ECW'(1);
          state_d = kst_pkg::S_KRD;
        end
      end
      kst_pkg::S_KRD: begin
        e_raddr = EAW'(i_q);
        j_d     = i_q;
        if (i_q >= ecnt_q) begin
          k_d     = '0;
          state_d = kst_pkg::S_ERD;
        end else begin
          state_d = kst_pkg::S_KLD;
        end
      end
      kst_pkg::S_KLD: begin
        key_d   = e_rdata;
        e_raddr = EAW'(j_q - 1'b1);
        state_d = kst_pkg::S_CMP;
      end
      kst_pkg::S_CMP: begin
        e_waddr = EAW'(j_q);
        if (r_w > key_w) begin
          e_we    = 1'b1;
          e_wdata = e_rdata;
          j_d     = j_q - 1'b1;
          e_raddr = EAW'(j_q - ECW'(2));
          if (j_q == ECW'(1)) begin
            state_d = kst_pkg::S_PUT;
          end
        end else begin
          e_we    = 1'b1;
          e_wdata = key_q;
          i_d     = i_q + 1'b1;
          state_d = kst_pkg::S_KRD;
        end
      end
      kst_pkg::S_PUT: begin
        e_we    = 1'b1;
        e_waddr = EAW'(j_q);
        e_wdata = key_q;
        i_d     = i_q + 1'b1;
        state_d = kst_pkg::S_KRD;
      end
      kst_pkg::S_ERD: begin
        e_raddr = EAW'(k_q);
        if (k_q >= ecnt_q) begin
          state_d = kst_pkg::S_DONE;
        end else begin
          state_d = kst_pkg::S_ELD;
        end
      end
      kst_pkg::S_ELD: begin
        if (32'(r_src) >= 32'(nodes_q) || 32'(r_dst) >= 32'(nodes_q)) begin
          bad_d   = 1'b1;
          k_d     = k_q + 1'b1;
          state_d = kst_pkg::S_ERD;
        end else if (32'(tc_q) + 32'd1 >= 32'(nodes_q)) begin
          k_d     = k_q + 1'b1;
          state_d = kst_pkg::S_ERD;
        end else begin
          x_d     = NAW'(r_src);
          p_raddr = NAW'(r_src);
          b_d     = NAW'(r_dst);
          ew_d    = r_w;
          state_d = kst_pkg::S_WA;
        end
      end
      kst_pkg::S_WA: begin
        if (p_rdata == x_q) begin
          ra_d    = x_q;
          x_d     = b_q;
          p_raddr = b_q;
          state_d = kst_pkg::S_WB;
        end else begin
          x_d     = p_rdata;
          p_raddr = p_rdata;
        end
      end
      kst_pkg::S_WB: begin
        if (p_rdata == x_q) begin
          if (x_q != ra_q) begin
            p_we    = 1'b1;
            p_waddr = x_q;
            p_wdata = ra_q;
            tsum_d  = tsum_q + SW'(ew_q);
            tc_d    = tc_q + 1'b1;
          end
          k_d     = k_q + 1'b1;
          state_d = kst_pkg::S_ERD;
        end else begin
          x_d     = p_rdata;
          p_raddr = p_rdata;
        end
      end
      kst_pkg::S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          sav_d   = tot_q - tsum_q;
          te_d    = kst_pkg::TCNT_W'(tc_q);
          be_d    = bad_q;
          ecnt_d  = '0;
          tot_d   = '0;
          bad_d   = 1'b0;
          state_d = kst_pkg::S_LOAD;
        end
      end
      default: begin
        state_d = kst_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kst_pkg::S_LOAD;
      ncfg_q  <= kst_pkg::NCFG_W'(kst_pkg::NCFG_RESET);
      ecnt_q  <= '0;
      tot_q   <= '0;
      bad_q   <= 1'b0;
      ov_q    <= 1'b0;
      nodes_q <= '0;
      tc_q    <= '0;
      tsum_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        ncfg_q <= cfg_wdata_i;
      end
      ecnt_q  <= ecnt_d;
      tot_q   <= tot_d;
      bad_q   <= bad_d;
      ov_q    <= ov_d;
      nodes_q <= nodes_d;
      tc_q    <= tc_d;
      tsum_q  <= tsum_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    x_q   <= x_d;
    ra_q  <= ra_d;
    b_q   <= b_d;
    ew_q  <= ew_d;
    sav_q <= sav_d;
    te_q  <= te_d;
    be_q  <= be_d;
  end

  assign out_valid_o  = ov_q;
  assign savings_o    = sav_q;
  assign tree_edges_o = te_q;
  assign bad_edge_o   = be_q;

`include "kruskal_spanning_tree_savings_assert.svh"

  `KST_ASSERT_IMP(a_ecnt_max, 1'b1, 32'(ecnt_q) <= MAX_EDGES, "edge count overflow")
  `KST_ASSERT_IMP(a_tc_bound, state_q != kst_pkg::S_LOAD, (tc_q < nodes_q) || (tc_q == '0), "forest too big")
  `KST_ASSERT_NXT(a_last_clr, in_acc && last_i, state_q == kst_pkg::S_CLR, "last did not start finish")
  `KST_ASSERT_IMP(a_sort_j, state_q == kst_pkg::S_CMP, (j_q != '0) && (j_q <= i_q), "sort index out of range")

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking bench for kruskal_spanning_tree_savings: predicts the forest savings per graph.
// Uses kst_pkg widths and drives the block through plain tasks; a scoreboard class checks results.
`timescale 1ns / 1ps
module tb;

  typedef struct {
    logic [kst_pkg::SUM_W-1:0]  savings;
    logic [kst_pkg::TCNT_W-1:0] tree_edges;
    logic                       bad_edge;
  } forest_res_t;

  class forest_scoreboard;
    int unsigned src_q[$], dst_q[$], w_q[$];
    longint unsigned total;
    int unsigned node_cnt = kst_pkg::NCFG_RESET;
    forest_res_t expected_q[$];
    int errors, checked, graphs;

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function int unsigned root_of(int unsigned x,
                                  ref int unsigned par[kst_pkg::MAX_NODES_DEF]);
      int unsigned steps;
      steps = 0;
      while (x < kst_pkg::MAX_NODES_DEF && par[x] != x && steps < kst_pkg::MAX_NODES_DEF) begin
        x = par[x];
        steps++;
      end
      return x;
    endfunction

    function void note_request(int unsigned s, int unsigned d, int unsigned w, bit lst);
      int unsigned par[kst_pkg::MAX_NODES_DEF];
      int unsigned ss[$], sd[$], sw[$];
      int unsigned nodes, tcnt, ra, rb, ks, kd, kw;
      longint unsigned tsum;
      int j;
      forest_res_t r;
      if (src_q.size() < kst_pkg::MAX_EDGES_DEF) begin
        src_q.push_back(s); dst_q.push_back(d); w_q.push_back(w);
        total += w;
      end
      if (!lst) return;
      nodes = node_cnt > kst_pkg::MAX_NODES_DEF ? kst_pkg::MAX_NODES_DEF : node_cnt;
      for (int i = 0; i < kst_pkg::MAX_NODES_DEF; i++) par[i] = i;
      ss = src_q; sd = dst_q; sw = w_q;
      for (int i = 1; i < sw.size(); i++) begin
        ks = ss[i]; kd = sd[i]; kw = sw[i];
        j = i;
        while (j > 0 && sw[j-1] > kw) begin
          ss[j] = ss[j-1]; sd[j] = sd[j-1]; sw[j] = sw[j-1];
          j--;
        end
        ss[j] = ks; sd[j] = kd; sw[j] = kw;
      end
      tsum = 0; tcnt = 0; r.bad_edge = 0;
      for (int i = 0; i < sw.size(); i++) begin
        if (ss[i] >= nodes || sd[i] >= nodes) begin
          r.bad_edge = 1;
          continue;
        end
        if (tcnt + 1 >= nodes) continue;
        ra = root_of(ss[i], par);
        rb = root_of(sd[i], par);
        if (ra == rb || rb >= kst_pkg::MAX_NODES_DEF) continue;
        par[rb] = ra;
        tsum += sw[i];
        tcnt++;
      end
      r.savings = kst_pkg::SUM_W'(total - tsum);
      r.tree_edges = kst_pkg::TCNT_W'(tcnt);
      expected_q.push_back(r);
      src_q.delete(); dst_q.delete(); w_q.delete();
      total = 0;
      graphs++;
    endfunction

    task check_result(forest_res_t got);
      forest_res_t e;
      checked++;
      if (expected_q.size() == 0) begin
        report("result with no request pending");
        return;
      end
      e = expected_q.pop_front();
      if (got.savings !== e.savings)
        report($sformatf("savings got %0d exp %0d", got.savings, e.savings));
      if (got.tree_edges !== e.tree_edges)
        report($sformatf("tree_edges got %0d exp %0d", got.tree_edges, e.tree_edges));
      if (got.bad_edge !== e.bad_edge)
        report($sformatf("bad_edge got %0b exp %0b", got.bad_edge, e.bad_edge));
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [kst_pkg::NCFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 0, last_i = 0, out_ready_i = 0;
  logic [kst_pkg::NODE_W-1:0] src_node_i = '0, dst_node_i = '0;
  logic [kst_pkg::WIN_W-1:0] weight_i = '0;
  logic in_ready_o, out_valid_o, bad_edge_o;
  logic [kst_pkg::SUM_W-1:0] savings_o;
  logic [kst_pkg::TCNT_W-1:0] tree_edges_o;

  forest_scoreboard sb = new();
  int hold_req = 0;
  bit calm = 0;
  int n_edges = 0;

  always #2 clk_i = ~clk_i;

  kruskal_spanning_tree_savings dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .src_node_i, .dst_node_i, .weight_i, .last_i,
    .out_valid_o, .out_ready_i, .savings_o, .tree_edges_o, .bad_edge_o
  );

  function int draw_gap();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic send_edge(int unsigned s, int unsigned d, int unsigned w, bit lst);
    int g;
    g = draw_gap();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    src_node_i <= kst_pkg::NODE_W'(s);
    dst_node_i <= kst_pkg::NODE_W'(d);
    weight_i   <= kst_pkg::WIN_W'(w);
    last_i     <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(s, d, w, lst);
    n_edges++;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_nodes(int unsigned v);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= kst_pkg::NCFG_W'(v);
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.node_cnt = v & 11'h7FF;
  endtask

  task automatic random_graph(int max_e);
    int n, span;
    int unsigned s, d, w;
    n = $urandom_range(1, max_e);
    span = sb.node_cnt > kst_pkg::MAX_NODES_DEF ? kst_pkg::MAX_NODES_DEF : sb.node_cnt;
    for (int i = 0; i < n; i++) begin
      if (span == 0 || $urandom_range(0, 9) == 0) begin
        s = $urandom_range(0, 1023); d = $urandom_range(0, 1023);
      end else begin
        s = $urandom_range(0, span - 1); d = $urandom_range(0, span - 1);
      end
      case ($urandom_range(0, 7))
        0: w = 0;
        1: w = 16'hFFFF;
        2: w = $urandom_range(0, 7);
        default: w = $urandom_range(0, 65535);
      endcase
      send_edge(s, d, w, i == n - 1);
    end
  endtask

  // receiver
  initial begin
    int g;
    forest_res_t r;
    @(posedge rst_ni);
    forever begin
      if (hold_req > 0) begin
        g = hold_req;
        hold_req = 0;
      end else begin
        g = draw_gap();
      end
      if (g > 0) begin
        out_ready_i <= 0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
      r.savings = savings_o;
      r.tree_edges = tree_edges_o;
      r.bad_edge = bad_edge_o;
      sb.check_result(r);
    end
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned nc_list[8] = '{1, 2, 5, 16, 0, 2047, 300, 1024};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // extremes, self loop, duplicates, default node count
    send_edge(0, 1, 0, 0);
    send_edge(1023, 1022, 65535, 0);
    send_edge(5, 5, 7, 0);
    send_edge(1023, 0, 65535, 0);
    send_edge(0, 1, 3, 1);
    send_edge(682, 341, 16'hAAAA, 0);
    send_edge(341, 682, 16'h5555, 0);
    send_edge(1, 3, 1, 1);
    send_edge(7, 9, 12, 1);
    write_nodes(1);
    send_edge(0, 0, 9, 1);
    send_edge(0, 1, 5, 1);
    write_nodes(0);
    send_edge(0, 0, 4, 1);
    write_nodes(2047);
    send_edge(1023, 512, 100, 0);
    send_edge(511, 1023, 200, 1);
    write_nodes(4);
    send_edge(0, 1, 1, 0);
    send_edge(1, 2, 2, 0);
    send_edge(2, 3, 3, 0);
    send_edge(0, 3, 4, 0);
    send_edge(3, 4, 5, 1);

    foreach (nc_list[k]) begin
      write_nodes(nc_list[k] == 300 ? $urandom_range(1, 1024) : nc_list[k]);
      calm = (k == 3);
      repeat (k < 5 ? 10 : 6) random_graph(12);
      if (k == 6) begin
        // receiver stalls while several graphs queue up behind it
        drain();
        hold_req = 3000;
        repeat (4) random_graph(6);
        drain();
      end
    end
    calm = 0;

    write_nodes(1024);
    repeat (18) random_graph(12);

    drain();
    repeat (100) @(posedge clk_i);
    $display("covered node counts from zero to above the limit, bad endpoints, idle gaps,");
    $display("a long receiver stall: %0d graphs, %0d edges, %0d results, %0d mismatches",
             sb.graphs, n_edges, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/kst_pkg.sv
rtl/kst_ram.sv
rtl/kruskal_spanning_tree_savings.sv
tb/tb.sv
